// File: design/lgp_pkg.sv
package lgp_pkg;

  // Channel widths
  localparam int OP_W   = 2;
  localparam int IN_W   = 168;
  localparam int OUT_W  = 40;

  // Item kinds carried on tuser
  localparam logic [1:0] OP_INPUT = 2'd0;
  localparam logic [1:0] OP_BUS   = 2'd1;
  localparam logic [1:0] OP_LINE  = 2'd2;

  // Shot sequence limits
  localparam logic [31:0] SHOT_TOTAL = 32'd250000;
  localparam logic [31:0] SHOT_HI    = 32'd166666;
  localparam logic [31:0] SHOT_LO    = 32'd83333;
  localparam int          SHOT_W     = 18;

  // Port and light constants
  localparam logic [6:0]  BUS_MASK     = 7'h7C;
  localparam logic [6:0]  STATUS_RESET = 7'h4C;
  localparam logic [15:0] X_LIMIT      = 16'd21472;
  localparam logic [15:0] OFFSCREEN    = 16'hC000;
  localparam logic [31:0] PULSE_LEN    = 32'd16;
  localparam logic [31:0] COUNTER_IDLE = 32'h7FFFFFFF;
  localparam int          LIGHT_BIT    = 6;
  localparam int          TRIG_BIT     = 4;

  // Light delay divider
  localparam int DIV_N_W   = 18;
  localparam int DIV_D_W   = 16;
  localparam int DIV_CNT_W = 5;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic arm;
    logic out_load;
  } lgp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } lgp_stat_t;

endpackage

// File: design/lgp_div.sv
module lgp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lgp_pkg::DIV_N_W-1:0]   dividend,
  input  logic [lgp_pkg::DIV_D_W-1:0]   divisor,
  output logic                          done,
  output logic [lgp_pkg::DIV_N_W-1:0]   quotient
);

  logic                          busy;
  logic [lgp_pkg::DIV_CNT_W-1:0] cnt;
  logic [lgp_pkg::DIV_N_W-1:0]   dvd;
  logic [lgp_pkg::DIV_D_W-1:0]   rem;
  logic [lgp_pkg::DIV_D_W:0]     shifted;
  logic                          fits;

  // one restoring step: bring in next dividend bit, subtract if it fits
  assign shifted = {rem, dvd[lgp_pkg::DIV_N_W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == lgp_pkg::DIV_CNT_W'(lgp_pkg::DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // payload: dividend shifts out, quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[lgp_pkg::DIV_N_W-2:0], 1'b0};
      rem      <= fits ? lgp_pkg::DIV_D_W'(shifted - {1'b0, divisor})
                       : shifted[lgp_pkg::DIV_D_W-1:0];
      quotient <= {quotient[lgp_pkg::DIV_N_W-2:0], fits};
    end
  end

endmodule

// File: design/lgp_datapath.sv
module lgp_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  lgp_pkg::lgp_cmd_t         cmd,
  output lgp_pkg::lgp_stat_t        stat,
  input  logic [lgp_pkg::IN_W-1:0]  s_tdata,
  input  logic [lgp_pkg::OP_W-1:0]  s_tuser,
  output logic [lgp_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tuser
);

  // latched item
  logic [1:0]  op_r;
  logic [31:0] ts_r;
  logic [15:0] cx_r, cy_r, line_r, divr_r, adj_r;
  logic [7:0]  btn_r;
  logic [30:0] elapsed_r;
  logic [6:0]  bo_r, ba_r;

  // block state
  logic [6:0]  status_bits, status_bits_next;
  logic        wait_phase, wait_phase_next;
  logic [31:0] light_counter, light_counter_next;
  logic [31:0] last_time, last_time_next;
  logic [31:0] next_time, next_time_next;
  logic        event_off, event_off_next;
  logic        shot_active, shot_active_next;
  logic [lgp_pkg::SHOT_W-1:0] shot_counter, shot_counter_next;
  logic        prev_shot, prev_shot_next;
  logic [15:0] aim_x, aim_x_next, aim_y, aim_y_next;
  logic [6:0]  data_r, data_next;

  // result word
  logic [6:0]  out_data;
  logic [31:0] out_ts;
  logic        out_off;

  // helpers
  logic [31:0] lc_sub;
  logic        lc_expired;
  logic [6:0]  status_adv;
  logic [31:0] shot_sum;
  logic signed [16:0] row_diff;
  logic        row_hit, col_hit;
  logic [17:0] x_sum;
  logic [19:0] num;
  logic        num_pos;
  logic        div_done;
  logic [lgp_pkg::DIV_N_W-1:0] quot;

  // item capture, fields from the lowest bit up
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= s_tuser;
      ts_r      <= s_tdata[31:0];
      cx_r      <= s_tdata[47:32];
      cy_r      <= s_tdata[63:48];
      btn_r     <= s_tdata[71:64];
      elapsed_r <= s_tdata[102:72];
      bo_r      <= s_tdata[109:103];
      ba_r      <= s_tdata[116:110];
      line_r    <= s_tdata[132:117];
      divr_r    <= s_tdata[148:133];
      adj_r     <= s_tdata[164:149];
    end
  end

  // light counter advance to the item's timestamp
  assign lc_sub     = light_counter - (ts_r - last_time);
  assign lc_expired = (lc_sub == 32'd0) || lc_sub[31];
  always_comb begin
    status_adv = status_bits;
    if (lc_expired) status_adv[lgp_pkg::LIGHT_BIT] = wait_phase;
  end

  // line hook hit test and delay numerator
  assign row_diff = $signed({aim_y[15], aim_y}) - $signed({line_r[15], line_r});
  assign row_hit  = (row_diff >= -17'sd1) && (row_diff <= 17'sd1);
  assign col_hit  = !aim_x[15] && (aim_x < lgp_pkg::X_LIMIT) && (divr_r != 16'd0);
  assign x_sum    = {{2{aim_x[15]}}, aim_x} + {{2{adj_r[15]}}, adj_r};
  assign num      = {x_sum, 2'b00};
  assign num_pos  = !num[19] && (num != 20'd0);

  assign stat.need_div = (op_r == lgp_pkg::OP_LINE) && row_hit && col_hit && num_pos;
  assign stat.div_done = div_done;

  lgp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.exec && stat.need_div),
    .dividend (num[lgp_pkg::DIV_N_W-1:0]),
    .divisor  (divr_r),
    .done     (div_done),
    .quotient (quot)
  );

  assign shot_sum = 32'(shot_counter) + 32'(elapsed_r);

  // next state
  always_comb begin
    status_bits_next   = status_bits;
    wait_phase_next    = wait_phase;
    light_counter_next = light_counter;
    last_time_next     = last_time;
    next_time_next     = next_time;
    event_off_next     = event_off;
    shot_active_next   = shot_active;
    shot_counter_next  = shot_counter;
    prev_shot_next     = prev_shot;
    aim_x_next         = aim_x;
    aim_y_next         = aim_y;
    data_next          = data_r;

    if (cmd.exec) begin
      data_next = 7'd0;
      unique case (op_r)
        lgp_pkg::OP_INPUT: begin
          aim_x_next       = cx_r;
          aim_y_next       = cy_r;
          status_bits_next = {status_bits[6], ~btn_r[1], ~btn_r[0], 4'b1100};
          if (shot_active) begin
            if (shot_sum >= lgp_pkg::SHOT_TOTAL) begin
              shot_active_next  = 1'b0;
              shot_counter_next = '0;
            end else begin
              shot_counter_next = shot_sum[lgp_pkg::SHOT_W-1:0];
              aim_x_next        = lgp_pkg::OFFSCREEN;
              aim_y_next        = lgp_pkg::OFFSCREEN;
              // trigger low only in the middle third
              status_bits_next[lgp_pkg::TRIG_BIT] =
                (shot_sum >= lgp_pkg::SHOT_HI) || (shot_sum < lgp_pkg::SHOT_LO);
            end
          end else if (btn_r[2] && !prev_shot) begin
            shot_active_next  = 1'b1;
            shot_counter_next = '0;
          end
          prev_shot_next = btn_r[2];
        end
        lgp_pkg::OP_BUS, lgp_pkg::OP_LINE: begin
          last_time_next     = ts_r;
          light_counter_next = lc_sub;
          status_bits_next   = status_adv;
          if (lc_expired) begin
            if (!wait_phase) begin
              wait_phase_next    = 1'b1;
              light_counter_next = lgp_pkg::PULSE_LEN;
              next_time_next     = ts_r + lgp_pkg::PULSE_LEN;
              event_off_next     = 1'b0;
            end else begin
              light_counter_next = lgp_pkg::COUNTER_IDLE;
              next_time_next     = 32'd0;
              event_off_next     = 1'b1;
            end
          end
          if (op_r == lgp_pkg::OP_BUS)
            data_next = ((bo_r & ba_r) | (status_adv & ~ba_r)) & lgp_pkg::BUS_MASK;
        end
        default: begin
        end
      endcase
    end

    // arm the light pulse once the delay is known
    if (cmd.arm && (quot != '0)) begin
      status_bits_next[lgp_pkg::LIGHT_BIT] = 1'b1;
      wait_phase_next    = 1'b0;
      light_counter_next = 32'(quot);
      next_time_next     = ts_r + 32'(quot);
      event_off_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_bits   <= lgp_pkg::STATUS_RESET;
      wait_phase    <= 1'b1;
      light_counter <= lgp_pkg::COUNTER_IDLE;
      last_time     <= 32'd0;
      next_time     <= 32'd0;
      event_off     <= 1'b1;
      shot_active   <= 1'b0;
      shot_counter  <= '0;
      prev_shot     <= 1'b0;
      aim_x         <= 16'd0;
      aim_y         <= 16'd0;
    end else begin
      status_bits   <= status_bits_next;
      wait_phase    <= wait_phase_next;
      light_counter <= light_counter_next;
      last_time     <= last_time_next;
      next_time     <= next_time_next;
      event_off     <= event_off_next;
      shot_active   <= shot_active_next;
      shot_counter  <= shot_counter_next;
      prev_shot     <= prev_shot_next;
      aim_x         <= aim_x_next;
      aim_y         <= aim_y_next;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= data_r;
      out_ts   <= event_off ? 32'd0 : next_time;
      out_off  <= event_off;
    end
  end

  assign m_tdata = {1'b0, out_ts, out_data};
  assign m_tuser = out_off;

endmodule

// File: design/lgp_ctrl.sv
module lgp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  lgp_pkg::lgp_stat_t  stat,
  output lgp_pkg::lgp_cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state, state_next;

  assign s_tready = (state == ST_IDLE);

  // sequencing
  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.need_div ? ST_DIV : ST_RESULT;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.arm    = 1'b1;
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

// File: design/light_gun_port_model_top.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tuser: op; tdata: timestamp .. coord_adjust
// m_        out  m_tvalid/m_tready  tdata: bus_data, next_event_ts; tuser: event_disabled
//
// One word in flight at a time: accept, execute, then the result
// is loaded into the output register before the next word is accepted.
// A scanline hit adds the 18-step serial divide; the pulse is armed once it is done.
// Reset is synchronous and restores the port state; the next word is taken
// while the previous result still waits on m_tready, and a finished word holds
// its result until the output register is free.
module light_gun_port_model_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // [31:0] timestamp, [47:32] coord_x, [63:48] coord_y, [71:64] buttons,
  // [102:72] elapsed_ticks, [109:103] bus_out, [116:110] bus_asserted,
  // [132:117] scan_row, [148:133] divisor, [164:149] coord_adjust
  input  logic [lgp_pkg::IN_W-1:0]  s_tdata,
  // [1:0] op
  input  logic [lgp_pkg::OP_W-1:0]  s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [6:0] bus_data, [38:7] next_event_ts
  output logic [lgp_pkg::OUT_W-1:0] m_tdata,
  // [0] event_disabled
  output logic                      m_tuser
);

  lgp_pkg::lgp_cmd_t  cmd;
  lgp_pkg::lgp_stat_t stat;

  lgp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lgp_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
